### hdl/ffha_pkg.sv
// ffha_pkg: shared types, codes and field widths of the first-fit heap allocator
// used by first_fit_heap_allocator, its port checker and the testbench; no dependencies
`timescale 1ns / 1ps

package ffha_pkg;

  // payload field widths
  localparam int REQ_W       = 17;
  localparam int ADDR_W      = 16;
  localparam int SIZE_W      = 17;
  localparam int OFF_W       = 16;
  localparam int STATUS_W    = 2;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 24;

  // smallest payload that a split may leave behind
  localparam int SPLIT_MIN_PAYLOAD = 4;

  typedef enum logic {
    CMD_ALLOC   = 1'b0,
    CMD_RELEASE = 1'b1
  } ffha_cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 2'd0,
    ST_ZERO   = 2'd1,
    ST_NOFIT  = 2'd2,
    ST_BADPTR = 2'd3
  } ffha_status_e;

  // one row of the block table
  typedef struct packed {
    logic              free;
    logic [SIZE_W-1:0] size;
    logic [OFF_W-1:0]  off;
  } ffha_entry_t;

endpackage

### hdl/first_fit_heap_allocator.sv
// Steps: alloc scans for the first free fit and marks it used, or on a split shifts later rows
//   up and writes the free tail and the used block; release scans for the pointer, reads the next
//   block and, on a merge, shifts later rows down; zero size and null release skip the scan.
// Throughput: one item at a time; one table row read and one written per cycle sets the scan
//   and shift length. A result may wait while the next item runs.
// Reset: asynchronous, active low; table holds one free block, no clearing pass.
// first_fit_heap_allocator: first-fit allocator with split and forward coalesce
// depends on ffha_pkg
`timescale 1ns / 1ps

module first_fit_heap_allocator
  import ffha_pkg::*;
#(
  parameter int HEAP_BYTES   = 65536,
  parameter int HEADER_BYTES = 12,
  parameter int MAX_BLOCKS   = 64
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // req_size[16:0], addr[32:17], zero pad
  input  logic                   s_axis_tuser,   // cmd
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata    // addr_out[15:0], status[17:16], zero pad
);

  localparam int IDX_W = $clog2(MAX_BLOCKS);
  localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
  localparam int SZX_W = SIZE_W + 1;
  localparam logic [SIZE_W-1:0] HDR_S  = SIZE_W'(HEADER_BYTES);
  localparam logic [OFF_W-1:0]  HDR_O  = OFF_W'(HEADER_BYTES);
  localparam logic [SIZE_W-1:0] SIZE0  = SIZE_W'(HEAP_BYTES - HEADER_BYTES);
  localparam logic [CNT_W-1:0]  MAXCNT = CNT_W'(MAX_BLOCKS);

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN, S_ALOC, S_SHUP, S_SPLN, S_SPLC, S_RNXT, S_RCHK, S_SHDN, S_DONE
  } state_e;

  state_e               state_q;
  ffha_cmd_e            cmd_q;
  logic [REQ_W-1:0]     req_q;
  logic [ADDR_W-1:0]    addr_q;
  logic [CNT_W-1:0]     cnt_q;
  logic [CNT_W-1:0]     idx_q;
  logic                 pv_q;
  logic [IDX_W-1:0]     pj_q;
  logic [IDX_W-1:0]     f_q;
  logic [IDX_W-1:0]     wdst_q;
  ffha_entry_t          ent_q;
  logic [OFF_W-1:0]     res_addr_q;
  ffha_status_e         res_st_q;
  logic                 v0_q;
  logic                 rsub_q;
  logic                 out_valid_q;
  logic [OFF_W-1:0]     out_addr_q;
  ffha_status_e         out_st_q;

  ffha_entry_t          mem_q [MAX_BLOCKS];
  ffha_entry_t          rdat_q;

  ffha_entry_t          rd_eff;
  ffha_entry_t          wdata;
  ffha_entry_t          reset_ent;
  logic                 we;
  logic [IDX_W-1:0]     waddr;
  logic [IDX_W-1:0]     raddr;
  logic                 match;
  logic                 issue;
  logic                 split;
  logic                 issue_up;
  logic                 issue_dn;
  logic                 has_next;
  logic                 out_free;
  logic [SIZE_W-1:0]    nsize;
  logic [OFF_W-1:0]     noff;
  logic [SIZE_W-1:0]    msize;

  // entry 0 reads as the reset block until it is first written
  assign reset_ent = '{free: 1'b1, size: SIZE0, off: '0};
  assign rd_eff    = rsub_q ? reset_ent : rdat_q;

  // scan compare: first free fit, or payload offset (header offset plus header) match on release
  always_comb begin
    if (cmd_q == CMD_RELEASE) begin
      match = pv_q && (({1'b0, rd_eff.off} + HDR_S) == {1'b0, addr_q});
    end else begin
      match = pv_q && rd_eff.free && (rd_eff.size >= req_q);
    end
  end

  assign issue    = idx_q < cnt_q;
  assign split    = (SZX_W'(ent_q.size) >= (SZX_W'(req_q) + SZX_W'(HDR_S)
                    + SZX_W'(SPLIT_MIN_PAYLOAD))) && (cnt_q < MAXCNT);
  assign issue_up = idx_q > (CNT_W'(f_q) + CNT_W'(1));
  assign issue_dn = (idx_q + CNT_W'(1)) < cnt_q;
  assign has_next = (CNT_W'(f_q) + CNT_W'(1)) < cnt_q;
  assign out_free = !out_valid_q || m_axis_tready;
  assign nsize    = ent_q.size - req_q[SIZE_W-1:0] - HDR_S;
  assign noff     = ent_q.off + HDR_O + req_q[OFF_W-1:0];
  assign msize    = ent_q.size + HDR_S + rd_eff.size;

  // table port control
  always_comb begin
    we    = 1'b0;
    waddr = f_q;
    wdata = ent_q;
    raddr = idx_q[IDX_W-1:0];
    unique case (state_q)
      S_ALOC: begin
        we    = !split;
        wdata = '{free: 1'b0, size: ent_q.size, off: ent_q.off};
      end
      S_SHUP: begin
        we    = pv_q;
        waddr = wdst_q;
        wdata = rd_eff;
        raddr = idx_q[IDX_W-1:0] - IDX_W'(1);
      end
      S_SPLN: begin
        we    = 1'b1;
        waddr = f_q + IDX_W'(1);
        wdata = '{free: 1'b1, size: nsize, off: noff};
      end
      S_SPLC: begin
        we    = 1'b1;
        wdata = '{free: 1'b0, size: req_q[SIZE_W-1:0], off: ent_q.off};
      end
      S_RNXT: begin
        we    = !has_next;
        raddr = f_q + IDX_W'(1);
        wdata = '{free: 1'b1, size: ent_q.size, off: ent_q.off};
      end
      S_RCHK: begin
        we    = 1'b1;
        wdata = '{free: 1'b1, size: rd_eff.free ? msize : ent_q.size, off: ent_q.off};
      end
      S_SHDN: begin
        we    = pv_q;
        waddr = wdst_q;
        wdata = rd_eff;
        raddr = idx_q[IDX_W-1:0] + IDX_W'(1);
      end
      default: begin
      end
    endcase
  end

  // block table memory, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    rdat_q <= mem_q[raddr];
  end

  // sequencer and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cmd_q       <= CMD_ALLOC;
      req_q       <= '0;
      addr_q      <= '0;
      cnt_q       <= CNT_W'(1);
      idx_q       <= '0;
      pv_q        <= 1'b0;
      pj_q        <= '0;
      f_q         <= '0;
      wdst_q      <= '0;
      ent_q       <= '0;
      res_addr_q  <= '0;
      res_st_q    <= ST_OK;
      v0_q        <= 1'b0;
      rsub_q      <= 1'b0;
      out_valid_q <= 1'b0;
      out_addr_q  <= '0;
      out_st_q    <= ST_OK;
    end else begin
      rsub_q <= (raddr == '0) && !v0_q;
      if (we && (waddr == '0)) begin
        v0_q <= 1'b1;
      end
      // result transfer frees the output register unless a new result loads it
      if (out_valid_q && m_axis_tready && (state_q != S_DONE)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            cmd_q      <= ffha_cmd_e'(s_axis_tuser);
            req_q      <= s_axis_tdata[REQ_W-1:0];
            addr_q     <= s_axis_tdata[REQ_W +: ADDR_W];
            idx_q      <= '0;
            pv_q       <= 1'b0;
            res_addr_q <= '0;
            res_st_q   <= ST_OK;
            if (ffha_cmd_e'(s_axis_tuser) == CMD_ALLOC) begin
              if (s_axis_tdata[REQ_W-1:0] == '0) begin
                res_st_q <= ST_ZERO;
                state_q  <= S_DONE;
              end else begin
                state_q  <= S_SCAN;
              end
            end else if (s_axis_tdata[REQ_W +: ADDR_W] == '0) begin
              state_q <= S_DONE;
            end else begin
              state_q <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (match) begin
            f_q     <= pj_q;
            ent_q   <= rd_eff;
            pv_q    <= 1'b0;
            state_q <= (cmd_q == CMD_ALLOC) ? S_ALOC : S_RNXT;
          end else if (issue) begin
            idx_q <= idx_q + CNT_W'(1);
            pj_q  <= idx_q[IDX_W-1:0];
            pv_q  <= 1'b1;
          end else if (pv_q) begin
            pv_q <= 1'b0;
          end else begin
            res_st_q <= (cmd_q == CMD_ALLOC) ? ST_NOFIT : ST_BADPTR;
            state_q  <= S_DONE;
          end
        end
        S_ALOC: begin
          res_addr_q <= ent_q.off + HDR_O;
          res_st_q   <= ST_OK;
          if (split) begin
            idx_q   <= cnt_q;
            pv_q    <= 1'b0;
            state_q <= S_SHUP;
          end else begin
            state_q <= S_DONE;
          end
        end
        S_SHUP: begin
          if (issue_up) begin
            wdst_q <= idx_q[IDX_W-1:0];
            idx_q  <= idx_q - CNT_W'(1);
            pv_q   <= 1'b1;
          end else begin
            pv_q    <= 1'b0;
            state_q <= S_SPLN;
          end
        end
        S_SPLN: begin
          state_q <= S_SPLC;
        end
        S_SPLC: begin
          cnt_q   <= cnt_q + CNT_W'(1);
          state_q <= S_DONE;
        end
        S_RNXT: begin
          state_q <= has_next ? S_RCHK : S_DONE;
        end
        S_RCHK: begin
          if (rd_eff.free) begin
            idx_q   <= CNT_W'(f_q) + CNT_W'(1);
            pv_q    <= 1'b0;
            state_q <= S_SHDN;
          end else begin
            state_q <= S_DONE;
          end
        end
        S_SHDN: begin
          if (issue_dn) begin
            wdst_q <= idx_q[IDX_W-1:0];
            idx_q  <= idx_q + CNT_W'(1);
            pv_q   <= 1'b1;
          end else begin
            pv_q    <= 1'b0;
            cnt_q   <= cnt_q - CNT_W'(1);
            state_q <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_addr_q  <= res_addr_q;
            out_st_q    <= res_st_q;
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // stream ports
  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {(OUT_TDATA_W - STATUS_W - OFF_W)'(0), out_st_q, out_addr_q};

endmodule

### hdl/ffha_checker.sv
// ffha_checker: port-level checks on first_fit_heap_allocator, attached by bind
// depends on ffha_pkg and first_fit_heap_allocator
`timescale 1ns / 1ps

module ffha_checker
  import ffha_pkg::*;
#(
  parameter int HEADER_BYTES = 12
) (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   s_axis_tvalid,
  input logic                   s_axis_tready,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  // a waiting result holds still until its transfer
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // one item in work at a time: ready drops after an input transfer
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken while busy");

  // a failed request never carries an address
  a_fail_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata[17:16] != ST_OK) |-> (m_axis_tdata[15:0] == 16'd0))
    else $error("address on failed request");

  // a granted payload offset lies past the first header
  a_grant_min: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata[17:16] == ST_OK) && (m_axis_tdata[15:0] != 16'd0)
    |-> (m_axis_tdata[15:0] >= 16'(HEADER_BYTES)))
    else $error("grant inside first header");

endmodule

bind first_fit_heap_allocator ffha_checker #(.HEADER_BYTES(HEADER_BYTES)) u_ffha_checker (.*);

### sim/ffha_grant_checker.sv
// ffha_grant_checker: watches both stream channels of the heap allocator, keeps its own
// block table to predict every grant and compares each result transfer; needs ffha_pkg
`timescale 1ns / 1ps

module ffha_grant_checker
  import ffha_pkg::*;
#(
  parameter int HEAP_BYTES   = 65536,
  parameter int HEADER_BYTES = 12,
  parameter int MAX_BLOCKS   = 64
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  input  logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // req_size[16:0], addr[32:17], zero pad
  input  logic                   s_axis_tuser,   // cmd
  input  logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  input  logic [OUT_TDATA_W-1:0] m_axis_tdata,   // addr_out[15:0], status[17:16], zero pad
  output int                     fail_cnt_o,
  output int                     pending_o
);

  typedef struct {
    logic [OFF_W-1:0] addr;
    ffha_status_e     status;
  } grant_t;

  // predicted heap layout, address ordered
  ffha_entry_t      heap_tab [MAX_BLOCKS];
  int unsigned      heap_cnt;
  grant_t           expected_grants [$];
  int               mismatches;
  grant_t           want;
  logic [OFF_W-1:0] got_addr;
  logic [1:0]       got_status;

  // one free block spanning the whole heap
  function automatic void heap_clear();
    for (int k = 0; k < MAX_BLOCKS; k++) heap_tab[k] = '0;
    heap_tab[0].free = 1'b1;
    heap_tab[0].size = SIZE_W'(HEAP_BYTES - HEADER_BYTES);
    heap_cnt = 1;
  endfunction

  // serve one command against the predicted table and return its grant
  function automatic grant_t heap_serve(ffha_cmd_e cmd, logic [REQ_W-1:0] req,
                                        logic [ADDR_W-1:0] ptr);
    grant_t      g;
    int unsigned i;
    int unsigned k;
    bit          done;
    g.addr   = '0;
    g.status = ST_OK;
    done     = 1'b0;
    if (cmd == CMD_ALLOC) begin
      if (req == '0) begin
        g.status = ST_ZERO;
      end else begin
        g.status = ST_NOFIT;
        for (i = 0; i < heap_cnt && !done; i++) begin
          if (heap_tab[i].free && heap_tab[i].size >= req) begin
            // split off the tail when it can hold a header and a minimal payload
            if (int'(heap_tab[i].size) >= int'(req) + HEADER_BYTES + SPLIT_MIN_PAYLOAD &&
                heap_cnt < MAX_BLOCKS) begin
              for (k = heap_cnt; k > i + 1; k--) heap_tab[k] = heap_tab[k-1];
              heap_tab[i+1].off  = OFF_W'(int'(heap_tab[i].off) + HEADER_BYTES + int'(req));
              heap_tab[i+1].size = SIZE_W'(int'(heap_tab[i].size) - int'(req) - HEADER_BYTES);
              heap_tab[i+1].free = 1'b1;
              heap_tab[i].size   = req;
              heap_cnt++;
            end
            heap_tab[i].free = 1'b0;
            g.addr   = OFF_W'(int'(heap_tab[i].off) + HEADER_BYTES);
            g.status = ST_OK;
            done     = 1'b1;
          end
        end
      end
    end else if (ptr != '0) begin
      g.status = ST_BADPTR;
      for (i = 0; i < heap_cnt && !done; i++) begin
        if (int'(heap_tab[i].off) + HEADER_BYTES == int'(ptr)) begin
          heap_tab[i].free = 1'b1;
          // forward coalesce only
          if (i + 1 < heap_cnt && heap_tab[i+1].free) begin
            heap_tab[i].size = SIZE_W'(int'(heap_tab[i].size) + HEADER_BYTES +
                                       int'(heap_tab[i+1].size));
            for (k = i + 1; k + 1 < heap_cnt; k++) heap_tab[k] = heap_tab[k+1];
            heap_cnt--;
          end
          g.status = ST_OK;
          done     = 1'b1;
        end
      end
    end
    return g;
  endfunction

  // result side is compared before the new item is predicted
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      heap_clear();
      expected_grants.delete();
      mismatches = 0;
      fail_cnt_o <= 0;
      pending_o  <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got_addr   = m_axis_tdata[OFF_W-1:0];
        got_status = m_axis_tdata[OFF_W +: STATUS_W];
        if (expected_grants.size() == 0) begin
          if (mismatches < 10)
            $display("%0t: result transfer with nothing expected: addr_out %0d status %0d",
                     $realtime, got_addr, got_status);
          mismatches++;
        end else begin
          want = expected_grants.pop_front();
          if (got_addr !== want.addr || got_status !== want.status) begin
            if (mismatches < 10)
              $display("%0t: mismatch: expected addr_out %0d status %s, got addr_out %0d status %0d",
                       $realtime, want.addr, want.status.name(), got_addr, got_status);
            mismatches++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        expected_grants.push_back(heap_serve(ffha_cmd_e'(s_axis_tuser),
                                             s_axis_tdata[REQ_W-1:0],
                                             s_axis_tdata[REQ_W +: ADDR_W]));
      fail_cnt_o <= mismatches;
      pending_o  <= expected_grants.size();
    end
  end

endmodule

### sim/first_fit_heap_allocator_test.sv
// first_fit_heap_allocator_test: drives allocate and release commands with bursty input and
// a stalling receiver, gives the verdict; depends on ffha_pkg, ffha_grant_checker and the dut
`timescale 1ns / 1ps

module first_fit_heap_allocator_test;
  import ffha_pkg::*;

  localparam int HEAP_BYTES    = 65536;
  localparam int HEADER_BYTES  = 12;
  localparam int MAX_BLOCKS    = 64;
  localparam int RANDOM_ITEMS  = 1300;
  localparam int HOLD_CYCLES   = 1500;
  localparam int STALL_LIMIT   = 20000;
  localparam int SETTLE_CYCLES = 4 * MAX_BLOCKS + 16;

  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic                   s_axis_tuser  = 1'b0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  int                     fail_cnt;
  int                     pending;
  int unsigned            items_sent = 0;
  int unsigned            burst_left = 0;
  logic [OFF_W-1:0]       live_ptrs [$];

  first_fit_heap_allocator #(
    .HEAP_BYTES  (HEAP_BYTES),
    .HEADER_BYTES(HEADER_BYTES),
    .MAX_BLOCKS  (MAX_BLOCKS)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  ffha_grant_checker #(
    .HEAP_BYTES  (HEAP_BYTES),
    .HEADER_BYTES(HEADER_BYTES),
    .MAX_BLOCKS  (MAX_BLOCKS)
  ) i_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .fail_cnt_o   (fail_cnt),
    .pending_o    (pending)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // collect granted payload offsets; a transfer at the next edge is already visible here
  always @(negedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready && m_axis_tdata[OFF_W +: STATUS_W] == ST_OK &&
        m_axis_tdata[OFF_W-1:0] != '0) begin
      live_ptrs.push_back(m_axis_tdata[OFF_W-1:0]);
      if (live_ptrs.size() > 96) void'(live_ptrs.pop_front());
    end
  end

  // one input transfer, with a random gap whenever a burst runs out
  task automatic issue(input ffha_cmd_e cmd, input logic [REQ_W-1:0] req,
                       input logic [ADDR_W-1:0] ptr);
    if (burst_left == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 30)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 200) : $urandom_range(1, 16);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {{(IN_TDATA_W - REQ_W - ADDR_W){1'b0}}, ptr, req};
    do @(posedge clk_i); while (!s_axis_tready);
    items_sent++;
    burst_left--;
  endtask

  // stop sending until every result has been taken
  task automatic drain_wait();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  // random command; the unused field always carries noise
  task automatic random_item(input int unsigned alloc_pct);
    int unsigned      pick;
    int unsigned      idx;
    logic [REQ_W-1:0] req;
    logic [ADDR_W-1:0] ptr;
    req  = REQ_W'($urandom);
    ptr  = ADDR_W'($urandom);
    pick = $urandom_range(1, 100);
    if ($urandom_range(1, 100) <= alloc_pct) begin
      if (pick <= 3) req = '0;
      else if (pick <= 58) req = REQ_W'($urandom_range(1, 64));
      else if (pick <= 83) req = REQ_W'($urandom_range(65, 2048));
      else if (pick <= 93) req = REQ_W'($urandom_range(2049, 70000));
      issue(CMD_ALLOC, req, ptr);
    end else begin
      if (pick <= 85 && live_ptrs.size() > 0) begin
        idx = $urandom_range(0, live_ptrs.size() - 1);
        ptr = live_ptrs[idx];
        // keep some pointers around so they get released twice
        if ($urandom_range(0, 6) != 0) live_ptrs.delete(idx);
      end else if (pick <= 90 && live_ptrs.size() > 0) begin
        // near miss of a live pointer
        ptr = live_ptrs[$urandom_range(0, live_ptrs.size() - 1)] ^
              ADDR_W'(1 << $urandom_range(0, 3));
      end else if (pick > 97) begin
        ptr = '0;
      end
      issue(CMD_RELEASE, req, ptr);
    end
  endtask

  // receiver: changing stall patterns and one long hold-off
  initial begin
    int unsigned mode;
    int unsigned mode_left;
    int unsigned stall_left;
    bit          hold_done;
    mode       = 0;
    mode_left  = 0;
    stall_left = 0;
    hold_done  = 1'b0;
    forever begin
      @(posedge clk_i);
      if (!hold_done && items_sent >= 200) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_done = 1'b1;
      end
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 3);
        mode_left = $urandom_range(20, 300);
      end
      mode_left--;
      case (mode)
        0: begin
          m_axis_tready <= 1'b1;
        end
        1: begin
          m_axis_tready <= 1'($urandom_range(0, 1));
        end
        2: begin
          m_axis_tready <= ($urandom_range(0, 3) == 0);
        end
        default: begin
          if (stall_left > 0) begin
            m_axis_tready <= 1'b0;
            stall_left--;
          end else begin
            m_axis_tready <= 1'b1;
            if ($urandom_range(0, 7) == 0) stall_left = $urandom_range(5, 40);
          end
        end
      endcase
    end
  end

  // watchdog on cycles without any transfer
  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) quiet = 0;
      else quiet++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  // stimulus and verdict
  initial begin
    int unsigned n;
    int unsigned alloc_pct;
    int unsigned phase_left;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // size extremes and the empty-heap corner cases
    issue(CMD_ALLOC,   17'd0,      16'hFFFF);   // zero size
    issue(CMD_ALLOC,   17'h1FFFF,  16'd0);      // far beyond the heap
    issue(CMD_ALLOC,   17'd65536,  16'd12);
    issue(CMD_ALLOC,   17'd65525,  16'd0);      // one byte too many
    issue(CMD_RELEASE, 17'h1FFFF,  16'd0);      // null release
    issue(CMD_RELEASE, 17'd0,      16'hFFFF);   // unknown pointer
    issue(CMD_RELEASE, 17'd5,      16'd12);     // release of a block that is already free
    issue(CMD_ALLOC,   17'd65524,  16'h5A5A);   // exact fit of the whole heap
    issue(CMD_ALLOC,   17'd1,      16'd0);      // nothing left
    issue(CMD_RELEASE, 17'd0,      16'd12);
    // splits down to the smallest remainder
    issue(CMD_ALLOC,   17'd1,      16'd0);
    issue(CMD_ALLOC,   17'd65495,  16'd0);
    issue(CMD_ALLOC,   17'd4,      16'd0);
    issue(CMD_ALLOC,   17'd1,      16'd0);
    issue(CMD_RELEASE, 17'd0,      16'd25);     // next block in use, no merge
    issue(CMD_RELEASE, 17'd0,      16'd65532);
    issue(CMD_RELEASE, 17'd0,      16'd25);     // released twice, now merges forward
    issue(CMD_RELEASE, 17'd0,      16'd13);     // header offset is not a payload offset
    issue(CMD_ALLOC,   17'd65496,  16'd0);      // remainder one byte short of a split
    issue(CMD_RELEASE, 17'd0,      16'd25);
    issue(CMD_RELEASE, 17'd0,      16'd12);     // merges back to a single block
    issue(CMD_ALLOC,   17'd65508,  16'd0);      // remainder exactly enough for a split
    issue(CMD_RELEASE, 17'd1234,   16'd12);
    drain_wait();

    // random phases that fill, drain or churn the table
    alloc_pct  = 50;
    phase_left = 0;
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (phase_left == 0) begin
        case ($urandom_range(0, 2))
          0:       alloc_pct = 80;
          1:       alloc_pct = 25;
          default: alloc_pct = 50;
        endcase
        phase_left = $urandom_range(40, 160);
      end
      phase_left--;
      if (n == RANDOM_ITEMS / 2) drain_wait();
      random_item(alloc_pct);
    end

    drain_wait();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (fail_cnt == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
